// ===== rtl/core/sdtq_pkg.sv =====
// Shared types, codes and defaults of the sorted deadline timer queue.
`default_nettype none
package sdtq_pkg;

    localparam int DEF_QUEUE_DEPTH  = 32;
    localparam int DEF_HANDLE_COUNT = 64;
    localparam int HANDLE_W         = 6;
    localparam int DEADLINE_W       = 32;
    localparam int STATUS_W         = 3;

    typedef logic [1:0] op_code_t;
    localparam op_code_t OP_ADD    = 2'd0;
    localparam op_code_t OP_ADJUST = 2'd1;
    localparam op_code_t OP_DELETE = 2'd2;
    localparam op_code_t OP_TICK   = 2'd3;

    typedef logic [STATUS_W-1:0] status_code_t;
    localparam status_code_t ST_DONE    = 3'd0;
    localparam status_code_t ST_EXPIRED = 3'd1;
    localparam status_code_t ST_NONE    = 3'd2;
    localparam status_code_t ST_PRESENT = 3'd3;
    localparam status_code_t ST_ABSENT  = 3'd4;
    localparam status_code_t ST_FULL    = 3'd5;

    typedef struct packed {
        op_code_t              op;
        logic [HANDLE_W-1:0]   handle;
        logic [DEADLINE_W-1:0] deadline;
        logic [DEADLINE_W-1:0] now;
    } cmd_item_t;

    typedef struct packed {
        status_code_t        status;
        logic [HANDLE_W-1:0] expired_handle;
        logic                last;
    } res_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REINSERT,
        S_TICK
    } ctrl_state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INSERT,
        WR_REMOVE,
        WR_SET_DEADLINE,
        WR_POP
    } write_op_t;

    typedef enum logic [1:0] {
        HSEL_CMD,
        HSEL_HEAD,
        HSEL_ZERO
    } handle_sel_t;

    typedef struct packed {
        logic         latch;
        write_op_t    write_op;
        logic         out_load;
        status_code_t out_status;
        handle_sel_t  out_handle_sel;
        logic         out_last;
    } dp_cmd_t;

    typedef struct packed {
        op_code_t op;
        logic     handle_bad;
        logic     found;
        logic     full;
        logic     adjust_in_place;
        logic     head_expired;
        logic     next_expired;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/sdtq_dpath.sv =====
// Datapath: sorted slot array, command register, comparators and result register.
`default_nettype none
module sdtq_dpath #(
    parameter int QUEUE_DEPTH  = sdtq_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_COUNT = sdtq_pkg::DEF_HANDLE_COUNT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  sdtq_pkg::cmd_item_t  cmd_item,
    input  sdtq_pkg::dp_cmd_t    dcmd,
    output sdtq_pkg::dp_status_t dsts,
    output sdtq_pkg::res_item_t  res_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic [sdtq_pkg::HANDLE_W-1:0]   slot_handle_reg   [QUEUE_DEPTH];
    logic [sdtq_pkg::DEADLINE_W-1:0] slot_deadline_reg [QUEUE_DEPTH];
    logic [sdtq_pkg::HANDLE_W-1:0]   slot_handle_next  [QUEUE_DEPTH];
    logic [sdtq_pkg::DEADLINE_W-1:0] slot_deadline_next[QUEUE_DEPTH];
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    sdtq_pkg::cmd_item_t             item_reg;
    sdtq_pkg::res_item_t             res_reg;
    sdtq_pkg::res_item_t             res_next;

    logic [QUEUE_DEPTH-1:0] valid;
    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] at_or_after;
    logic [QUEUE_DEPTH-1:0] pred_bad;
    logic [QUEUE_DEPTH-1:0] succ_bad;
    logic [IDX_W-1:0]       pos;

    // Per-slot comparisons; the valid slots always form a prefix in sorted order.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        assign valid[g] = CNT_W'(g) < count_reg;
        assign le[g]    = valid[g] && (slot_deadline_reg[g] <= item_reg.deadline);
        assign match[g] = valid[g] && (slot_handle_reg[g] == item_reg.handle);
        assign at_or_after[g] = IDX_W'(g) >= pos;

        if (g < QUEUE_DEPTH - 1) begin : g_pred
            assign pred_bad[g] = match[g+1] && (slot_deadline_reg[g] > item_reg.deadline);
        end else begin : g_pred_end
            assign pred_bad[g] = 1'b0;
        end
        if (g > 0) begin : g_succ
            assign succ_bad[g] = match[g-1] && valid[g]
                                 && (item_reg.deadline > slot_deadline_reg[g]);
        end else begin : g_succ_first
            assign succ_bad[g] = 1'b0;
        end

        always_comb
        begin
            slot_handle_next[g]   = slot_handle_reg[g];
            slot_deadline_next[g] = slot_deadline_reg[g];
            unique case (dcmd.write_op)
                sdtq_pkg::WR_INSERT:
                begin
                    if (!le[g])
                    begin
                        if (g == 0)
                        begin
                            slot_handle_next[g]   = item_reg.handle;
                            slot_deadline_next[g] = item_reg.deadline;
                        end else if (le[(g > 0) ? g - 1 : 0])
                        begin
                            slot_handle_next[g]   = item_reg.handle;
                            slot_deadline_next[g] = item_reg.deadline;
                        end else
                        begin
                            slot_handle_next[g]   = slot_handle_reg[(g > 0) ? g - 1 : 0];
                            slot_deadline_next[g] = slot_deadline_reg[(g > 0) ? g - 1 : 0];
                        end
                    end
                end
                sdtq_pkg::WR_REMOVE:
                begin
                    if (at_or_after[g] && g < QUEUE_DEPTH - 1)
                    begin
                        slot_handle_next[g]   = slot_handle_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                        slot_deadline_next[g] =
                            slot_deadline_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    end
                end
                sdtq_pkg::WR_POP:
                begin
                    if (g < QUEUE_DEPTH - 1)
                    begin
                        slot_handle_next[g]   = slot_handle_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                        slot_deadline_next[g] =
                            slot_deadline_reg[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    end
                end
                sdtq_pkg::WR_SET_DEADLINE:
                begin
                    if (match[g])
                    begin
                        slot_deadline_next[g] = item_reg.deadline;
                    end
                end
                default:
                begin
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            slot_handle_reg[g]   <= slot_handle_next[g];
            slot_deadline_reg[g] <= slot_deadline_next[g];
        end
    end

    // Position of the matching slot; at most one slot matches.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (match[i])
            begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        unique case (dcmd.write_op)
            sdtq_pkg::WR_INSERT:                    count_next = count_reg + CNT_W'(1);
            sdtq_pkg::WR_REMOVE, sdtq_pkg::WR_POP:  count_next = count_reg - CNT_W'(1);
            default:                                count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end else
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        res_next        = res_reg;
        if (dcmd.out_load)
        begin
            res_next.status = dcmd.out_status;
            res_next.last   = dcmd.out_last;
            unique case (dcmd.out_handle_sel)
                sdtq_pkg::HSEL_CMD:  res_next.expired_handle = item_reg.handle;
                sdtq_pkg::HSEL_HEAD: res_next.expired_handle = slot_handle_reg[0];
                default:             res_next.expired_handle = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.latch)
        begin
            item_reg <= cmd_item;
        end
        res_reg <= res_next;
    end

    assign res_item = res_reg;

    assign dsts.op              = item_reg.op;
    assign dsts.handle_bad      = 32'(item_reg.handle) >= 32'(HANDLE_COUNT);
    assign dsts.found           = |match;
    assign dsts.full            = count_reg >= CNT_W'(QUEUE_DEPTH);
    assign dsts.adjust_in_place = !(|pred_bad) && !(|succ_bad);
    assign dsts.head_expired    = valid[0] && (slot_deadline_reg[0] <= item_reg.now);
    assign dsts.next_expired    = valid[1] && (slot_deadline_reg[1] <= item_reg.now);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_unique_handle: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("handle held in more than one slot");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        valid[1] |-> slot_deadline_reg[0] <= slot_deadline_reg[1])
        else $error("first two slots out of deadline order");

endmodule
`default_nettype wire

// ===== rtl/core/sdtq_ctrl.sv =====
// Controller: state machine sequencing each item and owning the result valid.
`default_nettype none
module sdtq_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_stall,
    output logic                 res_valid,
    input  wire                  res_stall,
    input  sdtq_pkg::dp_status_t dsts,
    output sdtq_pkg::dp_cmd_t    dcmd
);

    sdtq_pkg::ctrl_state_t state_reg;
    sdtq_pkg::ctrl_state_t state_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic                  out_free;

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = state_reg != sdtq_pkg::S_IDLE;
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdtq_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        dcmd.latch          = 1'b0;
        dcmd.write_op       = sdtq_pkg::WR_NONE;
        dcmd.out_load       = 1'b0;
        dcmd.out_status     = sdtq_pkg::ST_DONE;
        dcmd.out_handle_sel = sdtq_pkg::HSEL_CMD;
        dcmd.out_last       = 1'b1;
        unique case (state_reg)
            sdtq_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    dcmd.latch = 1'b1;
                    state_next = sdtq_pkg::S_EXEC;
                end
            end
            sdtq_pkg::S_EXEC:
            begin
                if (dsts.op == sdtq_pkg::OP_TICK)
                begin
                    state_next = sdtq_pkg::S_TICK;
                end else if (out_free)
                begin
                    dcmd.out_load = 1'b1;
                    state_next    = sdtq_pkg::S_IDLE;
                    priority if (dsts.handle_bad)
                    begin
                        dcmd.out_status = sdtq_pkg::ST_ABSENT;
                    end else if (dsts.op == sdtq_pkg::OP_ADD)
                    begin
                        priority if (dsts.found)
                        begin
                            dcmd.out_status = sdtq_pkg::ST_PRESENT;
                        end else if (dsts.full)
                        begin
                            dcmd.out_status = sdtq_pkg::ST_FULL;
                        end else
                        begin
                            dcmd.write_op = sdtq_pkg::WR_INSERT;
                        end
                    end else if (!dsts.found)
                    begin
                        dcmd.out_status = sdtq_pkg::ST_ABSENT;
                    end else if (dsts.op == sdtq_pkg::OP_DELETE)
                    begin
                        dcmd.write_op = sdtq_pkg::WR_REMOVE;
                    end else if (dsts.adjust_in_place)
                    begin
                        dcmd.write_op = sdtq_pkg::WR_SET_DEADLINE;
                    end else
                    begin
                        dcmd.write_op = sdtq_pkg::WR_REMOVE;
                        dcmd.out_load = 1'b0;
                        state_next    = sdtq_pkg::S_REINSERT;
                    end
                end
            end
            sdtq_pkg::S_REINSERT:
            begin
                if (out_free)
                begin
                    dcmd.write_op = sdtq_pkg::WR_INSERT;
                    dcmd.out_load = 1'b1;
                    state_next    = sdtq_pkg::S_IDLE;
                end
            end
            sdtq_pkg::S_TICK:
            begin
                if (out_free)
                begin
                    dcmd.out_load = 1'b1;
                    if (dsts.head_expired)
                    begin
                        dcmd.write_op       = sdtq_pkg::WR_POP;
                        dcmd.out_status     = sdtq_pkg::ST_EXPIRED;
                        dcmd.out_handle_sel = sdtq_pkg::HSEL_HEAD;
                        dcmd.out_last       = !dsts.next_expired;
                        if (!dsts.next_expired)
                        begin
                            state_next = sdtq_pkg::S_IDLE;
                        end
                    end else
                    begin
                        dcmd.out_status     = sdtq_pkg::ST_NONE;
                        dcmd.out_handle_sel = sdtq_pkg::HSEL_ZERO;
                        state_next          = sdtq_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sdtq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (dcmd.out_load)
        begin
            res_valid_next = 1'b1;
        end else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end else
        begin
            res_valid_next = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_deadline_timer_queue_unit.sv =====
// Top level of the sorted deadline timer queue: controller plus slot datapath.
//
// Usage: commands arrive as items on the cmd channel (cmd_valid, cmd_stall,
// cmd_item) and results leave as items on the res channel (res_valid,
// res_stall, res_item). Add, adjust and delete each produce one result item
// with last set. A tick produces one result item per expired timer, in
// deadline order, with last set on the final one, or a single "nothing
// expired" item when no timer is due.
// A command item is taken in the idle state and its result is loaded in the
// execute state. An adjust that must move its timer removes it in the execute
// state and reinserts it in the reinsert state. A tick passes from the execute
// state to the tick state, where the head slot is popped and shifted out one
// timer per cycle while the receiver does not stall, or the "nothing expired"
// item is loaded when no timer is due.
// The command channel stalls while an item is in progress.
// Reset empties the queue at once by clearing the entry count; slot
// contents are not cleared and are never read beyond the count.
// When the receiver stalls, the result item is held in the output register
// and the controller waits before producing the next result.
`default_nettype none
module sorted_deadline_timer_queue_unit #(
    parameter int QUEUE_DEPTH  = sdtq_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_COUNT = sdtq_pkg::DEF_HANDLE_COUNT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_stall,
    input  sdtq_pkg::cmd_item_t cmd_item,
    output logic                res_valid,
    input  wire                 res_stall,
    output sdtq_pkg::res_item_t res_item
);

    // Command and status bundles between the controller and the datapath.
    sdtq_pkg::dp_cmd_t    dcmd;
    sdtq_pkg::dp_status_t dsts;

    sdtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .dsts      (dsts),
        .dcmd      (dcmd)
    );

    // The datapath holds the sorted slots and the registered result item.
    sdtq_dpath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .HANDLE_COUNT (HANDLE_COUNT)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_item (cmd_item),
        .dcmd     (dcmd),
        .dsts     (dsts),
        .res_item (res_item)
    );

endmodule
`default_nettype wire

// ===== bench/tb_sorted_deadline_timer_queue_unit.sv =====
// Testbench for the sorted deadline timer queue: directed and random command traffic.
`timescale 1ns / 100ps
module tb_sorted_deadline_timer_queue_unit;

    localparam int DEPTH        = 32;
    localparam int HANDLES      = 64;
    localparam int WATCHDOG_MAX = 20000;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    sdtq_pkg::cmd_item_t cmd_item;
    logic                res_valid;
    logic                res_stall;
    sdtq_pkg::res_item_t res_item;

    sorted_deadline_timer_queue_unit #(
        .QUEUE_DEPTH(DEPTH),
        .HANDLE_COUNT(HANDLES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item(cmd_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item(res_item)
    );

    // Shadow copy of the timer list, kept sorted by deadline like the block's slots.
    logic [sdtq_pkg::HANDLE_W-1:0]   shadow_handle[DEPTH];
    logic [sdtq_pkg::DEADLINE_W-1:0] shadow_deadline[DEPTH];
    int                              shadow_count;

    // Results still owed by the block, oldest first.
    sdtq_pkg::res_item_t owed_results[$];

    int  error_count;
    int  watchdog;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_off_cycles;

    // The clock runs with equal high and low phases.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Position of a handle in the shadow list, or the count when it is absent.
    function automatic int slot_of(logic [sdtq_pkg::HANDLE_W-1:0] h);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_handle[i] == h)
                return i;
        end
        return shadow_count;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_handle[i]   = shadow_handle[i + 1];
            shadow_deadline[i] = shadow_deadline[i + 1];
        end
        shadow_count--;
    endfunction

    // A new timer goes after every entry whose deadline is at most its own.
    function automatic void place_sorted(logic [sdtq_pkg::HANDLE_W-1:0] h,
                                         logic [sdtq_pkg::DEADLINE_W-1:0] d);
        int pos;
        pos = 0;
        while (pos < shadow_count && shadow_deadline[pos] <= d)
            pos++;
        for (int i = shadow_count; i > pos; i--)
        begin
            shadow_handle[i]   = shadow_handle[i - 1];
            shadow_deadline[i] = shadow_deadline[i - 1];
        end
        shadow_handle[pos]   = h;
        shadow_deadline[pos] = d;
        shadow_count++;
    endfunction

    function automatic void owe(sdtq_pkg::status_code_t st,
                                logic [sdtq_pkg::HANDLE_W-1:0] h, logic lst);
        sdtq_pkg::res_item_t r;
        r.status         = st;
        r.expired_handle = h;
        r.last           = lst;
        owed_results.push_back(r);
    endfunction

    // Applies one accepted command to the shadow list and queues its results.
    function automatic void predict_timer_results(sdtq_pkg::cmd_item_t c);
        int  pos;
        int  n;
        bit  pred_ok;
        bit  succ_ok;
        if (c.op == sdtq_pkg::OP_TICK)
        begin
            n = 0;
            while (shadow_count > 0 && shadow_deadline[0] <= c.now)
            begin
                owe(sdtq_pkg::ST_EXPIRED, shadow_handle[0], 1'b0);
                drop_slot(0);
                n++;
            end
            if (n == 0)
                owe(sdtq_pkg::ST_NONE, '0, 1'b1);
            else
                owed_results[$].last = 1'b1;
            return;
        end
        pos = slot_of(c.handle);
        if (c.op == sdtq_pkg::OP_ADD)
        begin
            if (pos < shadow_count)
                owe(sdtq_pkg::ST_PRESENT, c.handle, 1'b1);
            else if (shadow_count >= DEPTH)
                owe(sdtq_pkg::ST_FULL, c.handle, 1'b1);
            else
            begin
                place_sorted(c.handle, c.deadline);
                owe(sdtq_pkg::ST_DONE, c.handle, 1'b1);
            end
            return;
        end
        if (pos >= shadow_count)
        begin
            owe(sdtq_pkg::ST_ABSENT, c.handle, 1'b1);
            return;
        end
        if (c.op == sdtq_pkg::OP_ADJUST)
        begin
            pred_ok = (pos == 0) || (shadow_deadline[pos - 1] <= c.deadline);
            succ_ok = (pos + 1 >= shadow_count) || (c.deadline <= shadow_deadline[pos + 1]);
            if (pred_ok && succ_ok)
                shadow_deadline[pos] = c.deadline;
            else
            begin
                drop_slot(pos);
                place_sorted(c.handle, c.deadline);
            end
        end
        else
            drop_slot(pos);
        owe(sdtq_pkg::ST_DONE, c.handle, 1'b1);
    endfunction

    // Sends one item and waits until the block has accepted it. The sender may
    // idle first; valid stays high from one item to the next when it does not.
    task automatic send_command(sdtq_pkg::op_code_t op, int h, logic [31:0] d,
                                logic [31:0] t);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid         <= 1'b1;
        cmd_item.op       <= op;
        cmd_item.handle   <= h[sdtq_pkg::HANDLE_W-1:0];
        cmd_item.deadline <= d;
        cmd_item.now      <= t;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_timer_results(cmd_item);
    endtask

    // The sender stops offering items and the queue drains completely, then
    // the block's latency is waited out.
    task automatic wait_until_drained();
        cmd_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] random_deadline();
        case ($urandom_range(3, 0))
            0: return $urandom_range(40, 0);
            1: return 32'hFFFF_FFFF - $urandom_range(3, 0);
            default: return $urandom();
        endcase
    endfunction

    // Extremes of every field, each operation and each error case.
    task automatic test_directed();
        send_command(sdtq_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);
        send_command(sdtq_pkg::OP_ADJUST, 5, 7, 0);
        send_command(sdtq_pkg::OP_DELETE, 63, 0, 0);
        send_command(sdtq_pkg::OP_ADD, 0, 32'hFFFF_FFFF, 0);
        send_command(sdtq_pkg::OP_ADD, 63, 0, 0);
        send_command(sdtq_pkg::OP_ADD, 63, 9, 0);
        send_command(sdtq_pkg::OP_ADD, 21, 10, 32'hAAAA_AAAA);
        send_command(sdtq_pkg::OP_ADD, 42, 10, 32'h5555_5555);
        send_command(sdtq_pkg::OP_ADD, 7, 20, 0);
        // Adjust that stays in place, then ones that must move forward and back.
        send_command(sdtq_pkg::OP_ADJUST, 42, 15, 0);
        send_command(sdtq_pkg::OP_ADJUST, 42, 30, 0);
        send_command(sdtq_pkg::OP_ADJUST, 0, 1, 0);
        send_command(sdtq_pkg::OP_ADJUST, 21, 10, 0);
        send_command(sdtq_pkg::OP_TICK, 0, 0, 0);
        send_command(sdtq_pkg::OP_TICK, 0, 0, 9);
        send_command(sdtq_pkg::OP_DELETE, 7, 0, 0);
        send_command(sdtq_pkg::OP_DELETE, 7, 0, 0);
        send_command(sdtq_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);
        // Fill the queue and try one more add.
        for (int i = 0; i < DEPTH; i++)
            send_command(sdtq_pkg::OP_ADD, i, i % 3, 0);
        send_command(sdtq_pkg::OP_ADD, 50, 1, 0);
        send_command(sdtq_pkg::OP_TICK, 0, 0, 2);
        wait_until_drained();
    endtask

    // Mostly known handles so adjusts and deletes hit; ticks drain the list.
    task automatic test_random(int count);
        int          h;
        int          sel;
        logic [31:0] clock_now;
        clock_now = 0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1, 0) && shadow_count > 0)
                h = shadow_handle[$urandom_range(shadow_count - 1, 0)];
            else
                h = $urandom_range(HANDLES - 1, 0);
            sel = $urandom_range(99, 0);
            if (sel < 40)
                send_command(sdtq_pkg::OP_ADD, h, random_deadline(), $urandom());
            else if (sel < 65)
                send_command(sdtq_pkg::OP_ADJUST, h, random_deadline(), $urandom());
            else if (sel < 80)
                send_command(sdtq_pkg::OP_DELETE, h, $urandom(), $urandom());
            else
            begin
                clock_now = ($urandom_range(4, 0) == 0) ? $urandom() : clock_now + 3;
                send_command(sdtq_pkg::OP_TICK, $urandom_range(63, 0), $urandom(),
                             clock_now);
            end
        end
        wait_until_drained();
    endtask

    // The receiver holds off while commands keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_off_cycles = 300;
        for (int i = 0; i < 40; i++)
            send_command(sdtq_pkg::OP_ADD, $urandom_range(63, 0), $urandom_range(50, 0), 0);
        send_command(sdtq_pkg::OP_TICK, 0, 0, 32'hFFFF_FFFF);
        // The sender pauses until every result has come back.
        wait_until_drained();
        send_command(sdtq_pkg::OP_TICK, 0, 0, 0);
        wait_until_drained();
    endtask

    // The receiver stalls at random, or for a long stretch when one is asked for.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            res_stall       <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            res_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // Every accepted result is compared with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, res_item);
                error_count++;
            end
            else
            begin
                if (res_item.status !== owed_results[0].status
                    || res_item.expired_handle !== owed_results[0].expired_handle
                    || res_item.last !== owed_results[0].last)
                begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, owed_results[0], res_item);
                    error_count++;
                end
                void'(owed_results.pop_front());
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cmd_valid       = 1'b0;
        cmd_item        = '0;
        error_count     = 0;
        watchdog        = 0;
        shadow_count    = 0;
        hold_off_cycles = 0;
        send_idle_pct   = 26;
        recv_idle_pct   = 65;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(100);
        send_idle_pct = 65;
        recv_idle_pct = 26;
        test_random(90);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(76);
        test_backpressure();
        wait_until_drained();
        repeat (20) @(posedge clk);

        if (error_count == 0 && owed_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
